// File: rtl/frpl_pkg.sv
// Shared types, codes and defaults for the free region page locator.
`timescale 1ns / 1ps

package frpl_pkg;

    localparam int MAX_REGIONS_DEF = 32;
    localparam int PAGE_SHIFT_DEF  = 12;
    localparam int ADDR_W          = 64;
    localparam int IDX_W           = 52;
    localparam int TYPE_W          = 32;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [TYPE_W-1:0] FREE_TYPE = 32'd1;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] region_base;
        logic [ADDR_W-1:0] region_length;
        logic [TYPE_W-1:0] region_type;
        logic [IDX_W-1:0]  page_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] phys_addr;
    } t_out_word;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] length;
        logic              free;
    } t_region;

    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic              sub;
    } t_alu_req;

endpackage

// File: rtl/free_region_page_locator_unit.sv
// Top level of the free region page locator: sequencer, walk pipeline and result register.
`timescale 1ns / 1ps

// The block keeps a table of memory regions and finds the address of a free page.
// A command word is taken at a rising edge where start is high and busy is low.
// Each command gives exactly one result word, shown on o_result for one cycle
// while o_done is high; the receiver cannot hold it off and must take it then.
// Clear, append and the unused code finish at once: the result appears in the cycle
// after the command is taken and busy never rises, so a new command may follow
// in the very next cycle. An append to a full table leaves the table unchanged
// and reports table full.
// A query raises busy. It first does the bound check against the free byte total,
// then walks the table one entry per cycle through the single read port of the
// region memory, with the page count of one entry computed while the next is
// read. The running total, the bound check, the page subtraction of the walk
// and the final address add go through one shared 64-bit adder.
// Reset empties the table and zeroes the free byte total; memory contents are
// not cleared, since only entries below the entry count are ever read.

module free_region_page_locator_unit #(
    parameter int MAX_REGIONS = frpl_pkg::MAX_REGIONS_DEF,
    parameter int PAGE_SHIFT  = frpl_pkg::PAGE_SHIFT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  frpl_pkg::t_in_word  i_cmd,
    output logic                busy,
    output logic                o_done,
    output frpl_pkg::t_out_word o_result
);

    localparam int AW  = frpl_pkg::ADDR_W;
    localparam int XW  = frpl_pkg::IDX_W;
    localparam int CW  = $clog2(MAX_REGIONS + 1);
    localparam int IW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int PGW = AW - PAGE_SHIFT + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_ADDR  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_total, n_total;
    logic [XW-1:0]       r_idx,   n_idx;
    logic [CW-1:0]       r_rd_k,  n_rd_k;
    logic                r_m_vld, n_m_vld;
    logic                r_p_vld, n_p_vld;
    logic [PGW-1:0]      r_p_pages, n_p_pages;
    logic [AW-1:0]       r_p_base,  n_p_base;
    logic                r_p_free,  n_p_free;
    logic                r_done,  n_done;
    frpl_pkg::t_out_word r_res,   n_res;

    logic                w_accept;
    logic                w_full;
    logic                w_is_free;
    logic                w_we;
    logic                w_re;
    frpl_pkg::t_region   w_wdata;
    frpl_pkg::t_region   w_rdata;
    frpl_pkg::t_alu_req  w_alu_req;
    logic [AW-1:0]       w_alu_res;
    logic                w_alu_carry;
    logic                w_round;

    assign w_accept  = start && !busy;
    assign w_full    = (r_count == CW'(MAX_REGIONS));
    assign w_is_free = (i_cmd.region_type == frpl_pkg::FREE_TYPE);

    assign w_wdata.base   = i_cmd.region_base;
    assign w_wdata.length = i_cmd.region_length;
    assign w_wdata.free   = w_is_free;
    assign w_we = w_accept && (i_cmd.operation == frpl_pkg::OP_APPEND) && !w_full;

    // Reads are issued in walk order until every valid entry has been fetched.
    assign w_re = (r_state == S_WALK) && (r_rd_k < r_count);

    frpl_region_mem #(
        .DEPTH (MAX_REGIONS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_rd_k[IW-1:0]),
        .o_rdata (w_rdata)
    );

    // The shared adder serves the running total on append, the bound check,
    // the page subtraction of the walk and the final base plus offset.
    always_comb begin
        case (r_state)
            S_IDLE: begin
                w_alu_req.a   = r_total;
                w_alu_req.b   = i_cmd.region_length;
                w_alu_req.sub = 1'b0;
            end
            S_CHECK: begin
                w_alu_req.a   = r_total >> PAGE_SHIFT;
                w_alu_req.b   = AW'(r_idx);
                w_alu_req.sub = 1'b1;
            end
            S_WALK: begin
                w_alu_req.a   = AW'(r_idx);
                w_alu_req.b   = AW'(r_p_pages);
                w_alu_req.sub = 1'b1;
            end
            S_ADDR: begin
                w_alu_req.a   = r_p_base;
                w_alu_req.b   = AW'(r_idx) << PAGE_SHIFT;
                w_alu_req.sub = 1'b0;
            end
            default: begin
                w_alu_req.a   = '0;
                w_alu_req.b   = '0;
                w_alu_req.sub = 1'b0;
            end
        endcase
    end

    frpl_alu u_alu (
        .i_req   (w_alu_req),
        .o_res   (w_alu_res),
        .o_carry (w_alu_carry)
    );

    // A region holds its length in whole pages, rounded up.
    assign w_round = |w_rdata.length[PAGE_SHIFT-1:0];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_total   = r_total;
        n_idx     = r_idx;
        n_rd_k    = r_rd_k;
        n_m_vld   = 1'b0;
        n_p_vld   = 1'b0;
        n_p_pages = r_p_pages;
        n_p_base  = r_p_base;
        n_p_free  = r_p_free;
        n_done    = 1'b0;
        n_res     = r_res;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res.status    = frpl_pkg::ST_OK;
                    n_res.phys_addr = '0;
                    case (i_cmd.operation)
                        frpl_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_total = '0;
                            n_done  = 1'b1;
                        end
                        frpl_pkg::OP_APPEND: begin
                            n_done = 1'b1;
                            if (w_full) begin
                                n_res.status = frpl_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                                if (w_is_free) begin
                                    n_total = w_alu_carry ? '1 : w_alu_res;
                                end
                            end
                        end
                        frpl_pkg::OP_QUERY: begin
                            n_idx   = i_cmd.page_index;
                            n_state = S_CHECK;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                // A borrow here means the index lies beyond the page count of the free byte total.
                if (w_alu_carry) begin
                    n_res.status    = frpl_pkg::ST_NOT_FOUND;
                    n_res.phys_addr = '0;
                    n_done          = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_rd_k  = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_re) begin
                    n_rd_k  = r_rd_k + CW'(1);
                    n_m_vld = 1'b1;
                end
                if (r_m_vld) begin
                    n_p_vld   = 1'b1;
                    n_p_pages = {1'b0, w_rdata.length[AW-1:PAGE_SHIFT]} + PGW'(w_round);
                    n_p_base  = w_rdata.base;
                    n_p_free  = w_rdata.free;
                end
                if (r_p_vld && r_p_free) begin
                    if (w_alu_carry) begin
                        // The page falls inside this region; the base stays put.
                        n_state  = S_ADDR;
                        n_m_vld  = 1'b0;
                        n_p_vld  = 1'b0;
                        n_p_base = r_p_base;
                    end else begin
                        n_idx = w_alu_res[XW-1:0];
                    end
                end
                if (!r_p_vld && !r_m_vld && (r_rd_k == r_count)) begin
                    n_res.status    = frpl_pkg::ST_NOT_FOUND;
                    n_res.phys_addr = '0;
                    n_done          = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_ADDR: begin
                n_res.status    = frpl_pkg::ST_OK;
                n_res.phys_addr = w_alu_res;
                n_done          = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= '0;
            r_rd_k  <= '0;
            r_m_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_rd_k  <= n_rd_k;
            r_m_vld <= n_m_vld;
            r_p_vld <= n_p_vld;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_p_pages <= n_p_pages;
        r_p_base  <= n_p_base;
        r_p_free  <= n_p_free;
        r_res     <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // A result word is only shown once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while a query is still running");

    // A clear empties the table and answers right away.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.operation == frpl_pkg::OP_CLEAR))
        |=> (o_done && (r_count == '0) && (r_total == '0)))
        else $error("clear did not empty the table");

    // Any status other than found carries a zero address.
    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != frpl_pkg::ST_OK)) |-> (o_result.phys_addr == '0))
        else $error("failed command returned a nonzero address");

    // The entry count never passes the table depth, and a walk never reads past it.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(MAX_REGIONS)) && ((r_state != S_WALK) || (r_rd_k <= r_count)))
        else $error("entry count or walk pointer out of range");

    // An address add always ends the query on the next edge.
    a_addr_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR) |=> (o_done && (o_result.status == frpl_pkg::ST_OK)))
        else $error("found page did not report");

endmodule

// File: rtl/frpl_region_mem.sv
// Region table memory: one write port and one registered read port.
`timescale 1ns / 1ps

module frpl_region_mem #(
    parameter int DEPTH = frpl_pkg::MAX_REGIONS_DEF,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  frpl_pkg::t_region i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output frpl_pkg::t_region o_rdata
);

    frpl_pkg::t_region r_mem [DEPTH];
    frpl_pkg::t_region r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/frpl_alu.sv
// Shared 64-bit add/subtract unit with carry or borrow out.
`timescale 1ns / 1ps

module frpl_alu (
    input  frpl_pkg::t_alu_req           i_req,
    output logic [frpl_pkg::ADDR_W-1:0]  o_res,
    output logic                         o_carry
);

    logic [frpl_pkg::ADDR_W:0] w_sum;

    // On a subtract the top bit is the borrow, set when a < b.
    always_comb begin
        if (i_req.sub) begin
            w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
    end

    assign o_res   = w_sum[frpl_pkg::ADDR_W-1:0];
    assign o_carry = w_sum[frpl_pkg::ADDR_W];

endmodule
